// ===== hdl/efsm_pkg.sv =====
package efsm_pkg;

    // default table depth
    localparam int MAX_EXTENTS_DEF = 64;

    // command codes
    localparam logic [2:0] CMD_INIT     = 3'd0;
    localparam logic [2:0] CMD_ALLOC    = 3'd1;
    localparam logic [2:0] CMD_FREE     = 3'd2;
    localparam logic [2:0] CMD_FIRST    = 3'd3;
    localparam logic [2:0] CMD_LAST     = 3'd4;
    localparam logic [2:0] CMD_BEST     = 3'd5;
    localparam logic [2:0] CMD_EXACT    = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_NO_HIT    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // compare results for one table entry against the current range
    typedef struct packed {
        logic        e_le_rs;
        logic        s_ge_re;
        logic        s_lt_rs;
        logic        e_gt_re;
        logic        touch;
        logic        s_gt_ne;
        logic        s_lt_ns;
        logic        e_gt_ne;
        logic        len_ge;
        logic        len_eq;
        logic        len_lt_best;
        logic [32:0] ent_end;
        logic [31:0] left_len;
        logic [31:0] right_len;
        logic [31:0] tail_start;
    } eval_t;

endpackage

// ===== hdl/efsm_ram.sv =====
module efsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/efsm_eval.sv =====
module efsm_eval (
    input  logic [31:0]           ent_s,
    input  logic [31:0]           ent_l,
    input  logic [31:0]           rs,
    input  logic [32:0]           re,
    input  logic [32:0]           ns,
    input  logic [32:0]           ne,
    input  logic [31:0]           pc,
    input  logic [31:0]           best_len,
    output efsm_pkg::eval_t       ev
);
    import efsm_pkg::*;

    logic [32:0] s_ext;
    logic [32:0] e_ext;
    logic [32:0] right_full;

    // end page of the entry and its relation to the range
    always_comb
    begin
        s_ext          = {1'b0, ent_s};
        e_ext          = s_ext + {1'b0, ent_l};
        right_full     = e_ext - re;
        ev.ent_end     = e_ext;
        ev.e_le_rs     = e_ext <= {1'b0, rs};
        ev.s_ge_re     = s_ext >= re;
        ev.s_lt_rs     = ent_s < rs;
        ev.e_gt_re     = e_ext > re;
        ev.touch       = (e_ext >= {1'b0, rs}) && (s_ext <= re);
        ev.s_gt_ne     = s_ext > ne;
        ev.s_lt_ns     = s_ext < ns;
        ev.e_gt_ne     = e_ext > ne;
        ev.len_ge      = ent_l >= pc;
        ev.len_eq      = ent_l == pc;
        ev.len_lt_best = ent_l < best_len;
        ev.left_len    = rs - ent_s;
        ev.right_len   = right_full[31:0];
        ev.tail_start  = ent_s + (ent_l - pc);
    end

endmodule

// ===== hdl/extent_free_space_map.sv =====
// channel | signals                                         | transfer
// input   | in_valid, in_ready, command, start_page, page_count | in_valid & in_ready
// output  | out_valid, out_ready, status, found, result_start,  | out_valid & out_ready
//         | result_length                                   |
//
// one table entry is read per cycle, except while a split or insert writes its
// second entry; allocate and fit commands make one pass over the table, free
// makes a merge pass, then a copy pass; init, rejected and trivial commands go
// straight to the result. in_ready is high only when idle, from the cycle
// after the result transaction. reset clears the control registers, extent count
// among them, but not the table contents: no clearing pass.
// a result waits in its output register until out_ready.
module extent_free_space_map #(
    parameter int MAX_EXTENTS = efsm_pkg::MAX_EXTENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] start_page,
    input  logic [31:0] page_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] result_start,
    output logic [31:0] result_length
);
    import efsm_pkg::*;

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MERGE = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SPLIT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        bank_reg, bank_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic        ovf_reg, ovf_next;
    logic        hit_reg, hit_next;
    logic        placed_reg, placed_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] rs_reg, rs_next;
    logic [32:0] re_reg, re_next;
    logic [31:0] pc_reg, pc_next;
    logic [32:0] ns_reg, ns_next;
    logic [32:0] ne_reg, ne_next;
    logic [31:0] pend_s_reg, pend_s_next;
    logic [31:0] pend_l_reg, pend_l_next;
    logic [31:0] best_reg, best_next;
    logic        found_reg, found_next;
    logic [31:0] rstart_reg, rstart_next;
    logic [31:0] rlen_reg, rlen_next;
    logic [1:0]  status_reg, status_next;

    logic        wr_req;
    logic [63:0] wr_data;
    logic        we;
    logic        ovf_now;
    logic [63:0] rdata_a, rdata_b, rdata;
    logic [31:0] ent_s, ent_l;
    logic [32:0] in_sum;
    logic        range_ok;
    logic        at_end;
    eval_t       ev;

    // ping-pong table banks: read the active one, rebuild into the other
    efsm_ram #(.WIDTH(64), .DEPTH(MAX_EXTENTS)) u_bank_a (
        .clk   (clk),
        .we    (we && bank_reg),
        .waddr (n_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (idx_next[AW-1:0]),
        .rdata (rdata_a)
    );

    efsm_ram #(.WIDTH(64), .DEPTH(MAX_EXTENTS)) u_bank_b (
        .clk   (clk),
        .we    (we && !bank_reg),
        .waddr (n_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (idx_next[AW-1:0]),
        .rdata (rdata_b)
    );

    assign rdata = bank_reg ? rdata_b : rdata_a;
    assign ent_s = rdata[63:32];
    assign ent_l = rdata[31:0];

    // shared compare unit
    efsm_eval u_eval (
        .ent_s    (ent_s),
        .ent_l    (ent_l),
        .rs       (rs_reg),
        .re       (re_reg),
        .ns       (ns_reg),
        .ne       (ne_reg),
        .pc       (pc_reg),
        .best_len (best_reg),
        .ev       (ev)
    );

    assign in_sum   = {1'b0, start_page} + {1'b0, page_count};
    assign range_ok = (page_count != 32'd0) && !in_sum[32];
    assign at_end   = idx_reg == count_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        hit_next    = hit_reg;
        placed_next = placed_reg;
        cmd_next    = cmd_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        pc_next     = pc_reg;
        ns_next     = ns_reg;
        ne_next     = ne_reg;
        pend_s_next = pend_s_reg;
        pend_l_next = pend_l_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        rstart_next = rstart_reg;
        rlen_next   = rlen_reg;
        status_next = status_reg;
        wr_req      = 1'b0;
        wr_data     = {pend_s_reg, pend_l_reg};

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (in_valid)
                begin
                    cmd_next    = command;
                    rs_next     = start_page;
                    re_next     = in_sum;
                    pc_next     = page_count;
                    ns_next     = {1'b0, start_page};
                    ne_next     = in_sum;
                    n_next      = '0;
                    ovf_next    = 1'b0;
                    hit_next    = 1'b0;
                    placed_next = 1'b0;
                    found_next  = 1'b0;
                    rstart_next = '0;
                    rlen_next   = '0;
                    best_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (command)
                        CMD_INIT:
                        begin
                            // clip to the page space, write into the spare bank
                            wr_data = {start_page, in_sum[32] ? ~start_page : page_count};
                            if (wr_data[31:0] != 32'd0)
                            begin
                                wr_req     = 1'b1;
                                count_next = CW'(1);
                                bank_next  = !bank_reg;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (!range_ok)
                                status_next = ST_BAD_RANGE;
                            else if (count_reg == '0)
                                status_next = ST_NO_HIT;
                            else
                                state_next = S_SCAN;
                        end
                        CMD_FREE:
                        begin
                            if (!range_ok)
                                status_next = ST_BAD_RANGE;
                            else
                                state_next = S_MERGE;
                        end
                        CMD_FIRST, CMD_LAST, CMD_BEST, CMD_EXACT:
                        begin
                            if (page_count != 32'd0 && count_reg != '0)
                                state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MERGE:
            begin
                // grow the freed range over every touching extent
                if (at_end)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    if (ev.touch)
                    begin
                        if (ev.s_lt_ns)
                            ns_next = {1'b0, ent_s};
                        if (ev.e_gt_ne)
                            ne_next = ev.ent_end;
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_SCAN:
            begin
                if (at_end)
                begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (!hit_reg)
                                status_next = ST_NO_HIT;
                            else if (ovf_reg)
                                status_next = ST_FULL;
                            else
                            begin
                                count_next = n_reg;
                                bank_next  = !bank_reg;
                            end
                        end
                        CMD_FREE:
                        begin
                            // merged range goes last when nothing lies above it
                            if (!placed_reg)
                            begin
                                wr_req  = 1'b1;
                                wr_data = {ns_reg[31:0], 32'(ne_reg - ns_reg)};
                            end
                        end
                        default:
                        begin
                            if (found_reg)
                                rlen_next = pc_reg;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            wr_data = rdata;
                            if (ev.e_le_rs || ev.s_ge_re)
                            begin
                                wr_req = 1'b1;
                            end
                            else
                            begin
                                hit_next = 1'b1;
                                if (ev.s_lt_rs && ev.e_gt_re)
                                begin
                                    wr_req      = 1'b1;
                                    wr_data     = {ent_s, ev.left_len};
                                    pend_s_next = re_reg[31:0];
                                    pend_l_next = ev.right_len;
                                    idx_next    = idx_reg;
                                    state_next  = S_SPLIT;
                                end
                                else if (ev.s_lt_rs)
                                begin
                                    wr_req  = 1'b1;
                                    wr_data = {ent_s, ev.left_len};
                                end
                                else if (ev.e_gt_re)
                                begin
                                    wr_req  = 1'b1;
                                    wr_data = {re_reg[31:0], ev.right_len};
                                end
                            end
                        end
                        CMD_FREE:
                        begin
                            if (!ev.touch)
                            begin
                                wr_req = 1'b1;
                                if (!placed_reg && ev.s_gt_ne)
                                begin
                                    wr_data     = {ns_reg[31:0], 32'(ne_reg - ns_reg)};
                                    placed_next = 1'b1;
                                    pend_s_next = ent_s;
                                    pend_l_next = ent_l;
                                    idx_next    = idx_reg;
                                    state_next  = S_SPLIT;
                                end
                                else
                                begin
                                    wr_data = rdata;
                                end
                            end
                        end
                        CMD_FIRST:
                        begin
                            if (!found_reg && ev.len_ge)
                            begin
                                found_next  = 1'b1;
                                rstart_next = ent_s;
                            end
                        end
                        CMD_LAST:
                        begin
                            if (ev.len_ge)
                            begin
                                found_next  = 1'b1;
                                rstart_next = ev.tail_start;
                            end
                        end
                        CMD_BEST:
                        begin
                            if (ev.len_ge && (!found_reg || ev.len_lt_best))
                            begin
                                found_next  = 1'b1;
                                rstart_next = ent_s;
                                best_next   = ent_l;
                            end
                        end
                        CMD_EXACT:
                        begin
                            if (!found_reg && ev.len_eq)
                            begin
                                found_next  = 1'b1;
                                rstart_next = ent_s;
                            end
                        end
                        default:
                        begin
                            idx_next = idx_reg + CW'(1);
                        end
                    endcase
                end
            end

            S_SPLIT:
            begin
                // second write of a split or an insert
                wr_req     = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SCAN;
            end

            S_DONE:
            begin
                if (out_ready)
                begin
                    n_next     = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // write into the spare bank, flag overflow past the table depth
        we      = 1'b0;
        ovf_now = 1'b0;
        if (wr_req)
        begin
            if (n_reg == MAX_CNT)
                ovf_now = 1'b1;
            else
            begin
                we     = 1'b1;
                n_next = n_reg + CW'(1);
            end
        end
        ovf_next = ovf_next | ovf_now;

        // free finishes here once the last write is known
        if (state_reg == S_SCAN && at_end && cmd_reg == CMD_FREE)
        begin
            if (ovf_reg || ovf_now)
                status_next = ST_FULL;
            else
            begin
                count_next = n_next;
                bank_next  = !bank_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bank_reg   <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            placed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bank_reg   <= bank_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            hit_reg    <= hit_next;
            placed_reg <= placed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rs_reg     <= rs_next;
        re_reg     <= re_next;
        pc_reg     <= pc_next;
        ns_reg     <= ns_next;
        ne_reg     <= ne_next;
        pend_s_reg <= pend_s_next;
        pend_l_reg <= pend_l_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        rstart_reg <= rstart_next;
        rlen_reg   <= rlen_next;
        status_reg <= status_next;
    end

    assign in_ready      = state_reg == S_IDLE;
    assign out_valid     = state_reg == S_DONE;
    assign status        = status_reg;
    assign found         = found_reg;
    assign result_start  = rstart_reg;
    assign result_length = rlen_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("extent count beyond table depth");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_CNT)
        else $error("rebuild index beyond table depth");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (result_start == 32'd0 && result_length == 32'd0))
        else $error("result fields set without a found extent");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (in_ready && n_reg == '0))
        else $error("not idle after result transaction");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE || state_reg == S_SPLIT) |=> $stable(count_reg))
        else $error("extent count changed mid command");
`endif

endmodule
